### design/chls_pkg.sv
package chls_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int LED_COUNT    = 8;
   localparam int TABLE_LEN    = 24;
   localparam int FRAC_BITS    = 16;
   localparam int PRESCALE     = 24;

   localparam int ITER_COUNT = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int CNT_W      = $clog2(ITER_COUNT + 1);
   localparam int IDX_W      = $clog2(TABLE_LEN);

   localparam int STATUS_W = 8;
   localparam int MAG_W    = 16;
   localparam int AXIS_W   = MAG_W + 1;
   localparam int HEAD_W   = 9;
   localparam int ANG_W    = FRAC_BITS + HEAD_W;
   localparam int CW       = MAG_W + PRESCALE + 3;
   localparam int ZW       = 25;

   localparam int NEW_DATA_BIT = 3;

   localparam logic [MAG_W-1:0] OFFSET_RESET = MAG_W'(32'hFFFF / 2);

   localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(90 << FRAC_BITS);
   localparam logic [ANG_W-1:0] ANG_180 = ANG_W'(180 << FRAC_BITS);
   localparam logic [ANG_W-1:0] ANG_360 = ANG_W'(360 << FRAC_BITS);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_CENTER_OFFSET = 1'b0;

   typedef struct packed {
      logic                 done;
      logic signed [ZW-1:0] angle;
   } cordic_status_type;

   // atan(2^-i) in degrees, 16 fraction bits
   function automatic logic signed [ZW-1:0] atan_q16(input logic [IDX_W-1:0] idx);
      logic signed [ZW-1:0] r;
      case (idx)
         5'd0:    r = ZW'(2949120);
         5'd1:    r = ZW'(1740967);
         5'd2:    r = ZW'(919879);
         5'd3:    r = ZW'(466945);
         5'd4:    r = ZW'(234379);
         5'd5:    r = ZW'(117304);
         5'd6:    r = ZW'(58666);
         5'd7:    r = ZW'(29335);
         5'd8:    r = ZW'(14668);
         5'd9:    r = ZW'(7334);
         5'd10:   r = ZW'(3667);
         5'd11:   r = ZW'(1833);
         5'd12:   r = ZW'(917);
         5'd13:   r = ZW'(458);
         5'd14:   r = ZW'(229);
         5'd15:   r = ZW'(115);
         5'd16:   r = ZW'(57);
         5'd17:   r = ZW'(29);
         5'd18:   r = ZW'(14);
         5'd19:   r = ZW'(7);
         5'd20:   r = ZW'(4);
         5'd21:   r = ZW'(2);
         5'd22:   r = ZW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   // overlapping 90-degree sectors around the ring
   function automatic logic [LED_COUNT-1:0] sector_mask(input logic [HEAD_W-1:0] h);
      logic [LED_COUNT-1:0] m;
      m    = '0;
      m[0] = (h >= HEAD_W'(315)) || (h < HEAD_W'(45));
      m[2] = (h < HEAD_W'(90));
      m[4] = (h >= HEAD_W'(45)) && (h < HEAD_W'(135));
      m[6] = (h >= HEAD_W'(90)) && (h < HEAD_W'(180));
      m[7] = (h >= HEAD_W'(135)) && (h < HEAD_W'(225));
      m[5] = (h >= HEAD_W'(180)) && (h < HEAD_W'(270));
      m[3] = (h >= HEAD_W'(225)) && (h < HEAD_W'(315));
      m[1] = (h >= HEAD_W'(270)) && (h < HEAD_W'(360));
      return m;
   endfunction

endpackage

### design/chls_if.sv
interface chls_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  status_byte;
   logic [15:0] x_raw;
   logic [15:0] y_raw;

   modport source (output valid, output status_byte, output x_raw, output y_raw,
                   input ready);
   modport sink   (input valid, input status_byte, input x_raw, input y_raw,
                   output ready);
endinterface

interface chls_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] led_mask;
   logic [8:0] heading_degrees;
   logic       updated;

   modport source (output valid, output led_mask, output heading_degrees, output updated,
                   input ready);
   modport sink   (input valid, input led_mask, input heading_degrees, input updated,
                   output ready);
endinterface

### design/compass_heading_led_sector_top.sv
// channel  | dir | words                                   | handshake
// req_ch   | in  | status_byte, x_raw, y_raw               | valid/ready
// rsp_ch   | out | led_mask, heading_degrees, updated      | valid/ready
// apb      | in  | center_offset at byte address 0         | psel/penable, pready=1
//
// a poll without new data returns the held outputs in the cycle after accept
// a poll with new data passes from accept to rsp valid through setup, up to 16
// steps in the cordic rotation unit, angle fold and sector lookup; fewer steps
// when the residual component reaches zero early
// req_ch.ready is low while a word is in work or a result waits that is not taken
// synchronous reset clears control state, held heading and mask, offset 32767
module compass_heading_led_sector_top import chls_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   chls_req_if.sink              req_ch,
   chls_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_RUN  = 5'b00100,
      ST_POST = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [MAG_W-1:0]         center_offset;
   cordic_status_type        cordic_status;

   logic signed [AXIS_W-1:0] x_ff, x_in;
   logic signed [AXIS_W-1:0] y_ff, y_in;
   logic [HEAD_W-1:0]        heading_ff, heading_in;
   logic [LED_COUNT-1:0]     held_mask_ff, held_mask_in;
   logic [HEAD_W-1:0]        held_heading_ff, held_heading_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [LED_COUNT-1:0]     rsp_mask_ff, rsp_mask_in;
   logic [HEAD_W-1:0]        rsp_heading_ff, rsp_heading_in;
   logic                     rsp_updated_ff, rsp_updated_in;

   logic                     slot_free;
   logic                     accept;
   logic                     start;
   logic [MAG_W-1:0]         ax;
   logic [MAG_W-1:0]         ay;
   logic [ANG_W-1:0]         base;
   logic [ANG_W-1:0]         sum;
   logic [LED_COUNT-1:0]     new_mask;

   chls_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .center_offset (center_offset)
   );

   assign ax    = x_ff[AXIS_W-1] ? MAG_W'(-x_ff) : x_ff[MAG_W-1:0];
   assign ay    = y_ff[AXIS_W-1] ? MAG_W'(-y_ff) : y_ff[MAG_W-1:0];
   assign start = (state_ff == ST_PREP);

   chls_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .ax     (ax),
      .ay     (ay),
      .status (cordic_status)
   );

   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && slot_free;
   assign accept       = req_ch.valid && req_ch.ready;

   // first-quadrant angle, clamped, with the axis cases
   always_comb begin
      if (x_ff == '0) begin
         base = '0;
      end else if (y_ff == '0) begin
         base = ANG_90;
      end else if (cordic_status.angle < 0) begin
         base = '0;
      end else if (ANG_W'(cordic_status.angle) > ANG_90) begin
         base = ANG_90;
      end else begin
         base = ANG_W'(cordic_status.angle);
      end
   end

   // fold the quadrant and the 180 offset into one add
   always_comb begin
      case ({x_ff[AXIS_W-1], y_ff[AXIS_W-1]})
         2'b00:   sum = ANG_180 + base;
         2'b01:   sum = ANG_360 - base;
         2'b10:   sum = ANG_180 - base;
         default: sum = base;
      endcase
   end

   assign new_mask = sector_mask(heading_ff);

   always_comb begin
      state_in        = state_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      heading_in      = heading_ff;
      held_mask_in    = held_mask_ff;
      held_heading_in = held_heading_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_mask_in     = rsp_mask_ff;
      rsp_heading_in  = rsp_heading_ff;
      rsp_updated_in  = rsp_updated_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.status_byte[NEW_DATA_BIT]) begin
                  x_in     = $signed({1'b0, req_ch.x_raw}) - $signed({1'b0, center_offset});
                  y_in     = $signed({1'b0, req_ch.y_raw}) - $signed({1'b0, center_offset});
                  state_in = ST_PREP;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_mask_in    = held_mask_ff;
                  rsp_heading_in = held_heading_ff;
                  rsp_updated_in = 1'b0;
               end
            end
         end
         ST_PREP: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cordic_status.done) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            heading_in = sum[ANG_W-1:FRAC_BITS];
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               held_mask_in    = new_mask;
               held_heading_in = heading_ff;
               rsp_valid_in    = 1'b1;
               rsp_mask_in     = new_mask;
               rsp_heading_in  = heading_ff;
               rsp_updated_in  = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         held_mask_ff    <= '0;
         held_heading_ff <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         held_mask_ff    <= held_mask_in;
         held_heading_ff <= held_heading_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      y_ff           <= y_in;
      heading_ff     <= heading_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_updated_ff <= rsp_updated_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.led_mask        = rsp_mask_ff;
   assign rsp_ch.heading_degrees = rsp_heading_ff;
   assign rsp_ch.updated         = rsp_updated_ff;

endmodule

### design/chls_csr.sv
module chls_csr import chls_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [MAG_W-1:0]      center_offset
);

   logic [MAG_W-1:0] center_ff;
   logic [MAG_W-1:0] center_in;
   logic             wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_CENTER_OFFSET);

   always_comb begin
      center_in = center_ff;
      if (wr_hit) begin
         center_in = pwdata[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= OFFSET_RESET;
      end else begin
         center_ff <= center_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_CENTER_OFFSET) begin
         prdata = CSR_DATA_W'(center_ff);
      end
   end

   assign center_offset = center_ff;

endmodule

### design/chls_cordic.sv
module chls_cordic import chls_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MAG_W-1:0]  ax,
   input  logic [MAG_W-1:0]  ay,
   output cordic_status_type status
);

   logic signed [CW-1:0] u_ff, u_in;
   logic signed [CW-1:0] v_ff, v_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic signed [CW-1:0] du;
   logic signed [CW-1:0] dv;
   logic signed [ZW-1:0] step_ang;
   logic                 finish;

   // one vectoring rotation per cycle, shifts floor toward minus infinity
   assign du       = v_ff >>> cnt_ff;
   assign dv       = u_ff >>> cnt_ff;
   assign step_ang = atan_q16(IDX_W'(cnt_ff));
   assign finish   = (cnt_ff == CNT_W'(ITER_COUNT)) || (v_ff == '0);

   always_comb begin
      u_in    = u_ff;
      v_in    = v_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         u_in    = $signed({{(CW-MAG_W-PRESCALE){1'b0}}, ay, {PRESCALE{1'b0}}});
         v_in    = $signed({{(CW-MAG_W-PRESCALE){1'b0}}, ax, {PRESCALE{1'b0}}});
         z_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (finish) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (!v_ff[CW-1]) begin
               u_in = u_ff + du;
               v_in = v_ff - dv;
               z_in = z_ff + step_ang;
            end else begin
               u_in = u_ff - du;
               v_in = v_ff + dv;
               z_in = z_ff - step_ang;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      v_ff <= v_in;
      z_ff <= z_in;
   end

   assign status.done  = done_ff;
   assign status.angle = z_ff;

endmodule

### test/tb.sv
module tb;
   import chls_pkg::*;

   localparam int     CYCLE_LIMIT  = 400000;
   localparam int     SETTLE       = 25;
   localparam int     PHASE_POLLS  = 270;
   localparam int     ROT_STEPS    = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam longint DEG90        = 64'd90 << FRAC_BITS;
   localparam longint DEG180       = 64'd180 << FRAC_BITS;
   localparam logic [CSR_ADDR_W-1:0] OFFSET_ADDR = CSR_ADDR_W'(4 * int'(REG_CENTER_OFFSET));

   // atan(2^-i) in degrees, 16 fraction bits, rounded
   localparam longint ATAN_Q16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct packed {
      logic [7:0] mask;
      logic [8:0] heading;
      logic       updated;
   } reading_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   chls_req_if req_ch();
   chls_rsp_if rsp_ch();

   compass_heading_led_sector_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor state
   logic [15:0] center_offset_q;
   logic [7:0]  held_mask_q;
   logic [8:0]  held_heading_q;

   reading_type expected_readings[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          idle_on     = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("tb: mismatch %s got %0d want %0d at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   function automatic logic [7:0] ring_mask(input int h);
      logic [7:0] m;
      m    = '0;
      m[0] = (h >= 315) || (h < 45);
      m[2] = (h < 90);
      m[4] = (h >= 45) && (h < 135);
      m[6] = (h >= 90) && (h < 180);
      m[7] = (h >= 135) && (h < 225);
      m[5] = (h >= 180) && (h < 270);
      m[3] = (h >= 225) && (h < 315);
      m[1] = (h >= 270) && (h < 360);
      return m;
   endfunction

   // vectoring cordic on magnitudes, angle of ax over ay in degrees q16
   function automatic longint quadrant_angle(input longint ax, input longint ay);
      longint u, v, z, du, dv;
      z = 0;
      if (ax == 0) return 0;
      if (ay == 0) return DEG90;
      u = ay <<< PRESCALE;
      v = ax <<< PRESCALE;
      for (int i = 0; i < ROT_STEPS; i++) begin
         if (v == 0) break;
         du = v >>> i;
         dv = u >>> i;
         if (v > 0) begin
            u = u + du;
            v = v - dv;
            z = z + ATAN_Q16[i];
         end else begin
            u = u - du;
            v = v + dv;
            z = z - ATAN_Q16[i];
         end
      end
      if (z < 0) z = 0;
      if (z > DEG90) z = DEG90;
      return z;
   endfunction

   function automatic reading_type predict_reading(input logic [7:0] st,
                                                   input logic [15:0] xr,
                                                   input logic [15:0] yr);
      longint      x, y, phi, total;
      reading_type r;
      if (!st[NEW_DATA_BIT]) begin
         r.mask    = held_mask_q;
         r.heading = held_heading_q;
         r.updated = 1'b0;
         return r;
      end
      x   = longint'(xr) - longint'(center_offset_q);
      y   = longint'(yr) - longint'(center_offset_q);
      phi = quadrant_angle(x < 0 ? -x : x, y < 0 ? -y : y);
      if (y < 0) phi = DEG180 - phi;
      if (x < 0) phi = -phi;
      total = phi + DEG180;
      if (total < 0) total = 0;
      held_heading_q = 9'(total >>> FRAC_BITS);
      held_mask_q    = ring_mask(int'(held_heading_q));
      r.mask    = held_mask_q;
      r.heading = held_heading_q;
      r.updated = 1'b1;
      return r;
   endfunction

   task automatic send_poll(input logic [7:0] st, input logic [15:0] xr, input logic [15:0] yr);
      int gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.status_byte <= st;
      req_ch.x_raw       <= xr;
      req_ch.y_raw       <= yr;
      do @(posedge clock); while (!req_ch.ready);
      expected_readings.push_back(predict_reading(st, xr, yr));
   endtask

   // hold off until every reading is back and the block has settled
   task automatic wait_quiet();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_center_offset(input logic [15:0] value);
      wait_quiet();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= OFFSET_ADDR;
      pwdata  <= {16'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      center_offset_q = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {16'd0, value})
         report_mismatch("center_offset readback", int'(prdata), int'(value));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [7:0] random_status();
      logic [7:0] st;
      st                = 8'($urandom_range(0, 255));
      st[NEW_DATA_BIT]  = ($urandom_range(0, 4) != 0);
      return st;
   endfunction

   // offset plus a signed delta, wrapping at 16 bits
   function automatic logic [15:0] around_offset(input int delta);
      return 16'(int'(center_offset_q) + delta);
   endfunction

   task automatic send_random_poll();
      logic [15:0] xr, yr;
      int          d;
      xr = 16'($urandom_range(0, 65535));
      yr = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
         0, 1, 2, 3: ;
         4, 5: begin
            xr = around_offset($urandom_range(0, 16) - 8);
            yr = around_offset($urandom_range(0, 16) - 8);
         end
         6: begin
            if ($urandom_range(0, 1)) xr = center_offset_q;
            else yr = center_offset_q;
         end
         7: begin
            d  = $urandom_range(1, 32767);
            xr = around_offset($urandom_range(0, 1) ? d : -d);
            yr = around_offset($urandom_range(0, 1) ? d : -d);
         end
         8: begin
            xr = around_offset($urandom_range(0, 600) - 300);
            yr = around_offset($urandom_range(0, 600) - 300);
         end
         default: begin
            case ($urandom_range(0, 2))
               0: xr = 16'h0000;
               1: xr = 16'hffff;
               default: xr = center_offset_q;
            endcase
            case ($urandom_range(0, 2))
               0: yr = 16'h0000;
               1: yr = 16'hffff;
               default: yr = center_offset_q;
            endcase
         end
      endcase
      send_poll(random_status(), xr, yr);
   endtask

   // one checker for every reading that leaves the block
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_readings.size() == 0) begin
            report_mismatch("unexpected word, heading", int'(rsp_ch.heading_degrees), -1);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_ch.led_mask !== want.mask)
               report_mismatch("led_mask", int'(rsp_ch.led_mask), int'(want.mask));
            if (rsp_ch.heading_degrees !== want.heading)
               report_mismatch("heading_degrees", int'(rsp_ch.heading_degrees),
                               int'(want.heading));
            if (rsp_ch.updated !== want.updated)
               report_mismatch("updated", int'(rsp_ch.updated), int'(want.updated));
         end
      end
   end

   // result side back-pressure, drawn per word
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = idle_on ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && !reset));
      end
   end

   // cardinal and diagonal headings plus the degenerate vectors
   task automatic test_special_headings();
      logic [15:0] c;
      c = center_offset_q;
      send_poll(8'h00, 16'h1234, 16'h4321);     // stale right after reset
      send_poll(8'h08, c, c);                   // both zero
      send_poll(8'h08, c, 16'h0000);            // x zero, y negative
      send_poll(8'h08, c, 16'hffff);            // x zero, y positive
      send_poll(8'h08, 16'hffff, c);            // y zero, x positive
      send_poll(8'h08, 16'h0000, c);            // y zero, x negative
      send_poll(8'h08, 16'h0000, 16'h0000);
      send_poll(8'h08, 16'hffff, 16'hffff);
      send_poll(8'h08, 16'h0000, 16'hffff);
      send_poll(8'h08, 16'hffff, 16'h0000);
      send_poll(8'h08, c + 16'd100, c - 16'd100);
      send_poll(8'h08, c - 16'd7, c + 16'd7);
      send_poll(8'h08, c + 16'd1, c);
      send_poll(8'h08, c, c - 16'd1);
   endtask

   task automatic test_stale_polls();
      send_poll(8'hf7, 16'hffff, 16'h0000);
      send_poll(8'hff, 16'h2000, 16'h9000);
      send_poll(8'h00, 16'h0000, 16'hffff);
      send_poll(8'hf7, 16'h5555, 16'haaaa);
      send_poll(8'h08, 16'haaaa, 16'h5555);
   endtask

   task automatic test_offset_extremes();
      write_center_offset(16'h0000);
      send_poll(8'h08, 16'h0000, 16'h0000);
      send_poll(8'h08, 16'hffff, 16'h0000);
      send_poll(8'h08, 16'h0000, 16'hffff);
      send_poll(8'h08, 16'hffff, 16'hffff);
      write_center_offset(16'hffff);
      send_poll(8'h08, 16'hffff, 16'hffff);
      send_poll(8'h08, 16'h0000, 16'hffff);
      send_poll(8'h08, 16'hffff, 16'h0000);
      send_poll(8'h08, 16'h0000, 16'h0000);
      send_poll(8'h00, 16'h0000, 16'h0000);
   endtask

   task automatic test_random_phases();
      logic [15:0] offsets [6];
      offsets = '{16'd32767, 16'd0, 16'hffff, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'd1};
      for (int p = 0; p < 6; p++) begin
         write_center_offset(offsets[p]);
         idle_on = (p != 2);
         for (int n = 0; n < PHASE_POLLS; n++) begin
            if (n == PHASE_POLLS / 2) wait_quiet();
            send_random_poll();
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.status_byte = '0;
      req_ch.x_raw       = '0;
      req_ch.y_raw       = '0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      center_offset_q    = OFFSET_RESET;
      held_mask_q        = '0;
      held_heading_q     = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_special_headings();
      test_stale_polls();
      test_offset_extremes();
      test_random_phases();
      wait_quiet();

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
